/* rtl/assert_macros.svh */
// Assertion macros used by the RTL top level.
// Depends on nothing; define ASSERT_OFF to compile them away.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_IMPL(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
	else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst_n, pre, post) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
	else $error("assertion failed");
`else
`define ASSERT_IMPL(label, clk, rst_n, prop)
`define ASSERT_NEXT(label, clk, rst_n, pre, post)
`endif
`endif

/* rtl/rdte_pkg.sv */
// Shared types, constants and command structs of the route discovery engine.
// Depends on nothing.
package rdte_pkg;
	localparam int TABLE_DEPTH = 8;
	localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int MAX_OUT = 8;
	localparam int OCNT_W = $clog2(MAX_OUT + 1);
	localparam logic [7:0] NO_NEXT = 8'hFF;

	localparam logic [1:0] KIND_DISC = 2'd0;
	localparam logic [1:0] KIND_REQ = 2'd1;
	localparam logic [1:0] KIND_REP = 2'd2;
	localparam logic [1:0] KIND_TICK = 2'd3;

	localparam logic [1:0] ACT_NONE = 2'd0;
	localparam logic [1:0] ACT_BCAST = 2'd1;
	localparam logic [1:0] ACT_REPLY = 2'd2;
	localparam logic [1:0] ACT_DUP = 2'd3;

	localparam logic [2:0] REG_ADDR = 3'd0;
	localparam logic [2:0] REG_RLIFE = 3'd1;
	localparam logic [2:0] REG_DLIFE = 3'd2;
	localparam logic [2:0] REG_NRSSI = 3'd3;
	localparam logic [2:0] REG_NHOPS = 3'd4;

	typedef struct packed {
		logic [1:0] kind;
		logic [7:0] msg_id;
		logic [7:0] src_node;
		logic [7:0] dest_node;
		logic [7:0] from_node;
		logic [7:0] reply_hops;
		logic [15:0] reply_metric;
		logic signed [7:0] link_rssi;
	} req_t;

	typedef struct packed {
		logic [1:0] action;
		logic [7:0] out_id;
		logic [7:0] out_src;
		logic [7:0] out_dest;
		logic [7:0] next_node;
		logic [7:0] out_hops;
		logic [15:0] out_metric;
		logic route_changed;
		logic last;
	} res_t;

	typedef struct packed {
		logic [7:0] node_address;
		logic [15:0] route_lifetime;
		logic [15:0] discovery_lifetime;
		logic [15:0] no_route_rssi;
		logic [7:0] no_route_hops;
	} cfg_t;

	// controller to datapath
	typedef struct packed {
		logic load;
		logic div_start;
		logic decide;
		logic scan_step;
		logic finish;
		logic emit;
		logic emit_last;
		logic capture;
		logic show_held;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic div_done;
		logic single;
		logic improve;
		logic scan_end;
		logic hit;
	} sts_t;

	function automatic logic [7:0] hops_inc(input logic [7:0] h);
		return (h == 8'hFF) ? 8'hFF : h + 8'd1;
	endfunction
endpackage

/* rtl/rdte_if.sv */
// Valid/ready channel carrying one request or result payload.
// Depends on nothing; payload type is a parameter of the interface.
interface rdte_if #(parameter type payload_t = logic) (input logic clk);
	logic valid;
	logic ready;
	payload_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

/* rtl/rdte_regs.sv */
// APB-style register file of the route discovery engine.
// Depends on rdte_pkg.
module rdte_regs (
	input logic clk,
	input logic arst_n,
	input logic psel,
	input logic penable,
	input logic pwrite,
	input logic [4:0] paddr,
	input logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready,
	output rdte_pkg::cfg_t cfg
);
	import rdte_pkg::*;
	cfg_t cfg_q;
	logic [2:0] idx;
	assign idx = paddr[4:2];
	assign pready = 1'b1;
	assign cfg = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.node_address <= 8'd1;
			cfg_q.route_lifetime <= 16'd60;
			cfg_q.discovery_lifetime <= 16'd10;
			cfg_q.no_route_rssi <= 16'hFFFF;
			cfg_q.no_route_hops <= 8'hFF;
		end else if (psel && penable && pwrite) begin
			unique case (idx)
				REG_ADDR: cfg_q.node_address <= pwdata[7:0];
				REG_RLIFE: cfg_q.route_lifetime <= pwdata[15:0];
				REG_DLIFE: cfg_q.discovery_lifetime <= pwdata[15:0];
				REG_NRSSI: cfg_q.no_route_rssi <= pwdata[15:0];
				REG_NHOPS: cfg_q.no_route_hops <= pwdata[7:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			REG_ADDR: prdata = {24'd0, cfg_q.node_address};
			REG_RLIFE: prdata = {16'd0, cfg_q.route_lifetime};
			REG_DLIFE: prdata = {16'd0, cfg_q.discovery_lifetime};
			REG_NRSSI: prdata = {16'd0, cfg_q.no_route_rssi};
			REG_NHOPS: prdata = {24'd0, cfg_q.no_route_hops};
			default: prdata = 32'd0;
		endcase
	end
endmodule

/* rtl/rdte_div.sv */
// Restoring divider, one quotient bit per cycle, for the averaged metric.
// Depends on nothing beyond its own ports.
module rdte_div (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic [23:0] dividend,
	input logic [8:0] divisor,
	output logic done,
	output logic [23:0] quotient
);
	logic [23:0] quo_q;
	logic [8:0] rem_q;
	logic [8:0] dvs_q;
	logic [4:0] cnt_q;
	logic busy_q;
	logic [9:0] trial;

	assign trial = {rem_q, quo_q[23]} - {1'b0, dvs_q};
	assign quotient = quo_q;
	assign done = busy_q && (cnt_q == 5'd0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q <= 5'd0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q <= 5'd24;
		end else if (done) begin
			busy_q <= 1'b0;
		end else if (busy_q) begin
			cnt_q <= cnt_q - 5'd1;
		end
	end

	// The remainder stays below the divisor, so nine bits hold it.
	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= 9'd0;
			dvs_q <= divisor;
		end else if (busy_q && cnt_q != 5'd0) begin
			if (!trial[9]) begin
				rem_q <= trial[8:0];
				quo_q <= {quo_q[22:0], 1'b1};
			end else begin
				rem_q <= {rem_q[7:0], quo_q[23]};
				quo_q <= {quo_q[22:0], 1'b0};
			end
		end
	end
endmodule

/* rtl/rdte_datapath.sv */
// Datapath: route entry, discovery table, metric average and result build.
// Depends on rdte_pkg and rdte_div.
module rdte_datapath (
	input logic clk,
	input logic arst_n,
	input rdte_pkg::cfg_t cfg,
	input rdte_pkg::req_t req,
	input rdte_pkg::cmd_t cmd,
	output rdte_pkg::sts_t sts,
	output rdte_pkg::res_t res
);
	import rdte_pkg::*;

	req_t r_q;
	logic route_valid_q;
	logic [7:0] route_next_q, route_hops_q, route_target_q;
	logic [15:0] route_metric_q, route_age_q;
	logic [TABLE_DEPTH-1:0] dvalid_q;
	logic [31:0] dentry_q [TABLE_DEPTH];
	logic [15:0] dage_q [TABLE_DEPTH];
	logic [15:0] avg_q;
	logic changed_q;
	logic [IDX_W-1:0] scan_q;
	logic scan_done_q;
	logic [OCNT_W-1:0] ocnt_q;
	logic [7:0] hitnext_q;
	logic hit_q;

	logic [7:0] mag;
	logic [23:0] dividend, quotient;
	logic div_done;
	logic [TABLE_DEPTH-1:0] dup_vec, free_vec;
	logic dup;
	logic [IDX_W-1:0] free_idx;
	logic free_any;
	logic [31:0] scan_e;
	logic scan_match, scan_full, scan_last, scan_fwd;

	assign mag = r_q.link_rssi[7] ? 8'(-r_q.link_rssi) : r_q.link_rssi;
	assign dividend = ({8'd0, r_q.reply_metric} * {16'd0, r_q.reply_hops}) + {16'd0, mag};

	rdte_div u_div (
		.clk(clk), .arst_n(arst_n), .start(cmd.div_start),
		.dividend(dividend), .divisor({1'b0, r_q.reply_hops} + 9'd1),
		.done(div_done), .quotient(quotient)
	);

	always_comb begin
		for (int i = 0; i < TABLE_DEPTH; i++) begin
			dup_vec[i] = dvalid_q[i] && dentry_q[i][31:8] ==
				{r_q.msg_id, r_q.src_node, r_q.dest_node};
			free_vec[i] = !dvalid_q[i];
		end
		dup = |dup_vec;
		free_any = |free_vec;
		free_idx = '0;
		for (int i = TABLE_DEPTH - 1; i >= 0; i--)
			if (free_vec[i]) free_idx = IDX_W'(i);
	end

	assign scan_e = dentry_q[scan_q];
	assign scan_match = dvalid_q[scan_q] && scan_e[31:16] == {r_q.msg_id, r_q.src_node};
	assign scan_full = ocnt_q == OCNT_W'(MAX_OUT);
	assign scan_last = scan_q == IDX_W'(TABLE_DEPTH - 1);
	assign scan_fwd = scan_match && r_q.src_node != cfg.node_address && !scan_full;

	assign sts.div_done = div_done;
	assign sts.single = r_q.kind != KIND_REP;
	assign sts.improve = quotient[15:0] < route_metric_q && quotient[23:16] == 8'd0;
	assign sts.scan_end = scan_done_q;
	assign sts.hit = hit_q;

	// Result for the current event, built from registered state.
	always_comb begin
		res = '0;
		res.route_changed = changed_q;
		res.last = cmd.emit_last;
		if (r_q.kind == KIND_REP) begin
			if (hit_q) begin
				res.action = ACT_REPLY;
				res.out_id = r_q.msg_id;
				res.out_src = r_q.src_node;
				res.out_dest = r_q.dest_node;
				res.next_node = hitnext_q;
				res.out_hops = hops_inc(r_q.reply_hops);
				res.out_metric = avg_q;
			end
		end else if (r_q.kind == KIND_DISC) begin
			res.action = ACT_BCAST;
			res.out_id = r_q.msg_id;
			res.out_src = cfg.node_address;
			res.out_dest = r_q.dest_node;
		end else if (r_q.kind == KIND_REQ) begin
			if (r_q.dest_node == cfg.node_address) begin
				res.action = ACT_REPLY;
				res.out_id = r_q.msg_id;
				res.out_src = r_q.src_node;
				res.out_dest = r_q.dest_node;
				res.next_node = r_q.from_node;
				res.out_metric = cfg.no_route_rssi;
			end else if (hit_q) begin
				res.action = ACT_DUP;
			end else if (route_valid_q) begin
				res.action = ACT_REPLY;
				res.out_id = r_q.msg_id;
				res.out_src = r_q.src_node;
				res.out_dest = r_q.dest_node;
				res.next_node = r_q.from_node;
				res.out_hops = hops_inc(route_hops_q);
				res.out_metric = route_metric_q;
			end else begin
				res.action = ACT_BCAST;
				res.out_id = r_q.msg_id;
				res.out_src = r_q.src_node;
				res.out_dest = r_q.dest_node;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) r_q <= req;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			route_valid_q <= 1'b0;
			route_next_q <= NO_NEXT;
			route_hops_q <= 8'hFF;
			route_metric_q <= 16'hFFFF;
			route_age_q <= 16'd0;
			route_target_q <= 8'd0;
			dvalid_q <= '0;
			changed_q <= 1'b0;
			hit_q <= 1'b0;
			scan_q <= '0;
			scan_done_q <= 1'b0;
			ocnt_q <= '0;
			avg_q <= 16'd0;
			hitnext_q <= 8'd0;
		end else begin
			if (cmd.load) begin
				changed_q <= 1'b0;
				hit_q <= 1'b0;
				scan_q <= '0;
				scan_done_q <= 1'b0;
				ocnt_q <= '0;
			end
			if (cmd.decide) begin
				// single-result events act once the request is registered, replies once the divide ends
				unique case (r_q.kind)
					KIND_DISC: if (free_any) begin
						dvalid_q[free_idx] <= 1'b1;
						dentry_q[free_idx] <= {r_q.msg_id, cfg.node_address,
							r_q.dest_node, cfg.node_address};
						dage_q[free_idx] <= cfg.discovery_lifetime;
					end
					KIND_REQ: begin
						hit_q <= dup;
						if (r_q.dest_node != cfg.node_address && !dup &&
							!route_valid_q && free_any) begin
							dvalid_q[free_idx] <= 1'b1;
							dentry_q[free_idx] <= {r_q.msg_id, r_q.src_node,
								r_q.dest_node, r_q.from_node};
							dage_q[free_idx] <= cfg.discovery_lifetime;
						end
					end
					KIND_REP: if (sts.improve) begin
						route_target_q <= r_q.dest_node;
						route_hops_q <= r_q.reply_hops;
						route_next_q <= r_q.from_node;
						route_age_q <= cfg.route_lifetime;
						route_valid_q <= 1'b1;
						route_metric_q <= quotient[15:0];
						avg_q <= quotient[15:0];
						changed_q <= 1'b1;
					end
					KIND_TICK: begin
						if (route_valid_q && route_age_q != 16'd0) begin
							route_age_q <= route_age_q - 16'd1;
							if (route_age_q == 16'd1) begin
								route_valid_q <= 1'b0;
								route_next_q <= NO_NEXT;
								route_hops_q <= cfg.no_route_hops;
								route_metric_q <= cfg.no_route_rssi;
								changed_q <= 1'b1;
							end
						end
						for (int i = 0; i < TABLE_DEPTH; i++)
							if (dvalid_q[i] && dage_q[i] != 16'd0) begin
								dage_q[i] <= dage_q[i] - 16'd1;
								if (dage_q[i] == 16'd1) dvalid_q[i] <= 1'b0;
							end
					end
					default: ;
				endcase
			end
			if (cmd.scan_step) begin
				// One table entry per step; a forwarded match raises hit for one check.
				hit_q <= scan_fwd;
				if (scan_match && r_q.src_node != cfg.node_address)
					dvalid_q[scan_q] <= 1'b0;
				if (scan_fwd) begin
					hitnext_q <= scan_e[7:0];
					ocnt_q <= ocnt_q + OCNT_W'(1);
				end
				if (!scan_last) scan_q <= scan_q + IDX_W'(1);
				scan_done_q <= scan_last;
			end
			if (cmd.emit) hit_q <= 1'b0;
			if (cmd.finish) begin
				for (int i = 0; i < TABLE_DEPTH; i++)
					if (dup_vec[i]) dvalid_q[i] <= 1'b0;
			end
		end
	end
endmodule

/* rtl/rdte_ctrl.sv */
// Controller state machine sequencing load, divide, scan and result output.
// Depends on rdte_pkg.
module rdte_ctrl (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	output logic out_valid,
	input logic out_ready,
	input rdte_pkg::sts_t sts,
	output rdte_pkg::cmd_t cmd
);
	import rdte_pkg::*;
	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_DIV = 3'd1;
	localparam logic [2:0] S_WAIT = 3'd2;
	localparam logic [2:0] S_SCAN = 3'd3;
	localparam logic [2:0] S_HOLD = 3'd4;
	localparam logic [2:0] S_DEC = 3'd5;
	localparam logic [2:0] S_OUT = 3'd6;

	logic [2:0] state_q, state_d;
	logic pend_q, pend_d;
	logic improve_q, improve_d;

	always_comb begin
		cmd = '0;
		state_d = state_q;
		pend_d = pend_q;
		improve_d = improve_q;
		in_ready = 1'b0;
		out_valid = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d = S_DEC;
				end
			end
			S_DEC: begin
				if (sts.single) begin
					cmd.decide = 1'b1;
					state_d = S_OUT;
				end else begin
					cmd.div_start = 1'b1;
					state_d = S_DIV;
				end
			end
			S_DIV: if (sts.div_done) begin
				cmd.decide = 1'b1;
				improve_d = sts.improve;
				pend_d = 1'b0;
				state_d = sts.improve ? S_SCAN : S_OUT;
			end
			S_SCAN: begin
				cmd.scan_step = 1'b1;
				state_d = S_WAIT;
			end
			S_WAIT: begin
				// A new hit while one is pending sends the pending one out first.
				if (sts.hit && pend_q) begin
					state_d = S_HOLD;
				end else begin
					if (sts.hit) begin
						cmd.capture = 1'b1;
						pend_d = 1'b1;
					end
					state_d = sts.scan_end ? S_OUT : S_SCAN;
				end
			end
			S_HOLD: begin
				out_valid = 1'b1;
				cmd.show_held = 1'b1;
				if (out_ready) begin
					// the new hit takes the place of the one just sent
					cmd.emit = 1'b1;
					cmd.capture = 1'b1;
					state_d = sts.scan_end ? S_OUT : S_SCAN;
				end
			end
			S_OUT: begin
				out_valid = 1'b1;
				cmd.emit_last = 1'b1;
				cmd.show_held = pend_q;
				if (out_ready) begin
					cmd.finish = improve_q;
					improve_d = 1'b0;
					pend_d = 1'b0;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			pend_q <= 1'b0;
			improve_q <= 1'b0;
		end else begin
			state_q <= state_d;
			pend_q <= pend_d;
			improve_q <= improve_d;
		end
	end
endmodule

/* rtl/route_discovery_table_engine.sv */
// Route discovery engine, top level: registers, controller and datapath.
// Discovery, request and tick each give one result, decided once the request is registered.
// A reply first goes through the bit-serial average; an improving reply then scans each table
// entry and sends a result for each forwarded reply. One request is in flight at a time, and
// the engine waits while the sink stalls.
// Reset is asynchronous, active low; it clears the route, table valid bits and the registers.
`include "assert_macros.svh"
module route_discovery_table_engine (
	input logic clk,
	input logic arst_n,
	rdte_if.sink in_ch,
	rdte_if.source out_ch,
	input logic psel,
	input logic penable,
	input logic pwrite,
	input logic [4:0] paddr,
	input logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready
);
	import rdte_pkg::*;

	cfg_t cfg;
	cmd_t cmd;
	sts_t sts;
	res_t res;
	res_t held_q;

	rdte_regs u_regs (
		.clk(clk), .arst_n(arst_n), .psel(psel), .penable(penable),
		.pwrite(pwrite), .paddr(paddr), .pwdata(pwdata), .prdata(prdata),
		.pready(pready), .cfg(cfg)
	);

	rdte_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_ch.valid), .in_ready(in_ch.ready),
		.out_valid(out_ch.valid), .out_ready(out_ch.ready), .sts(sts), .cmd(cmd)
	);

	rdte_datapath u_dp (
		.clk(clk), .arst_n(arst_n), .cfg(cfg), .req(in_ch.data), .cmd(cmd),
		.sts(sts), .res(res)
	);

	// A forwarded reply is held here until the scan finds the next one or ends, since
	// only then is it known whether it is the final result. Other results are shown
	// straight from the datapath, which is stable while the controller waits on the sink.
	always_ff @(posedge clk) begin
		if (cmd.capture) held_q <= res;
	end

	always_comb begin
		out_ch.data = res;
		if (cmd.show_held) begin
			out_ch.data = held_q;
			out_ch.data.last = cmd.emit_last;
		end
	end

	`ASSERT_IMPL(a_no_both, clk, arst_n, !(in_ch.ready && out_ch.valid))
	`ASSERT_NEXT(a_accept_busy, clk, arst_n, in_ch.valid && in_ch.ready, !in_ch.ready)
	`ASSERT_IMPL(a_hold_no_last, clk, arst_n, !(cmd.emit && out_ch.data.last))
endmodule

/* bench/route_discovery_table_engine_test.sv */
// Self-checking bench for the route discovery engine: directed event sequences,
// then random traffic under several register settings, with random idling on both channels.
// Depends on rdte_pkg and rdte_if from the RTL, and on the engine itself.
module route_discovery_table_engine_test;
	timeunit 1ns;
	timeprecision 1ps;
	import rdte_pkg::*;

	localparam int CYCLE_LIMIT = 400000;
	localparam int DEPTH = 8;

	logic clk;
	logic arst_n;
	logic psel, penable, pwrite;
	logic [4:0] paddr;
	logic [31:0] pwdata, prdata;
	logic pready;

	rdte_if #(.payload_t(req_t)) in_ch (clk);
	rdte_if #(.payload_t(res_t)) out_ch (clk);

	route_discovery_table_engine dut (
		.clk(clk), .arst_n(arst_n), .in_ch(in_ch), .out_ch(out_ch),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	// Shadow copy of the registers, updated only while the engine is idle.
	logic [7:0] my_addr;
	logic [15:0] route_life, disc_life, nr_rssi;
	logic [7:0] nr_hops;

	// Shadow of the route entry and the pending-discovery table.
	logic rt_valid;
	logic [7:0] rt_next, rt_hops, rt_target;
	logic [15:0] rt_metric, rt_age;
	logic tbl_valid [DEPTH];
	logic [7:0] tbl_id [DEPTH], tbl_src [DEPTH], tbl_dest [DEPTH], tbl_snd [DEPTH];
	logic [15:0] tbl_age [DEPTH];

	res_t expected_results[$];
	res_t step_results[$];

	int errors = 0;
	int cycles = 0;
	int requests_sent = 0;
	int results_seen = 0;
	int forwards_seen = 0;
	int stall_left = 0;
	int hold_left = 0;
	bit no_idle = 0;

	initial clk = 0;
	always begin
		#1 clk = 1;
		#1 clk = 0;
	end

	// Global watchdog: a hung engine or a lost result ends the run here.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("FAIL route_discovery_table_engine");
			$finish;
		end
	end

	// Predictor helpers.
	function automatic res_t make_res(logic [1:0] act, logic [7:0] id, logic [7:0] src,
			logic [7:0] dest, logic [7:0] nxt, logic [7:0] hops, logic [15:0] met);
		res_t r;
		r = '0;
		r.action = act;
		r.out_id = id;
		r.out_src = src;
		r.out_dest = dest;
		r.next_node = nxt;
		r.out_hops = hops;
		r.out_metric = met;
		return r;
	endfunction

	function automatic void queue_result(res_t r);
		if (step_results.size() < MAX_OUT)
			step_results.push_back(r);
	endfunction

	function automatic logic [7:0] sat_inc(logic [7:0] h);
		return (h == 8'hFF) ? 8'hFF : h + 8'd1;
	endfunction

	function automatic void log_discovery(logic [7:0] id, logic [7:0] src, logic [7:0] dest,
			logic [7:0] snd);
		for (int i = 0; i < DEPTH; i++) begin
			if (!tbl_valid[i]) begin
				tbl_valid[i] = 1;
				tbl_id[i] = id;
				tbl_src[i] = src;
				tbl_dest[i] = dest;
				tbl_snd[i] = snd;
				tbl_age[i] = disc_life;
				return;
			end
		end
	endfunction

	// Works out the results of one accepted request and updates the shadow state.
	function automatic void predict_results(req_t rq);
		logic dup;
		logic changed;
		logic [31:0] mag, avg;
		res_t r;
		dup = 0;
		changed = 0;
		step_results.delete();
		case (rq.kind)
			KIND_DISC: begin
				log_discovery(rq.msg_id, my_addr, rq.dest_node, my_addr);
				queue_result(make_res(ACT_BCAST, rq.msg_id, my_addr, rq.dest_node, 0, 0, 0));
			end
			KIND_REQ: begin
				for (int i = 0; i < DEPTH; i++)
					if (tbl_valid[i] && tbl_id[i] == rq.msg_id && tbl_src[i] == rq.src_node
							&& tbl_dest[i] == rq.dest_node)
						dup = 1;
				if (rq.dest_node == my_addr) begin
					queue_result(make_res(ACT_REPLY, rq.msg_id, rq.src_node, rq.dest_node,
						rq.from_node, 0, nr_rssi));
				end else if (dup) begin
					queue_result(make_res(ACT_DUP, 0, 0, 0, 0, 0, 0));
				end else if (rt_valid) begin
					queue_result(make_res(ACT_REPLY, rq.msg_id, rq.src_node, rq.dest_node,
						rq.from_node, sat_inc(rt_hops), rt_metric));
				end else begin
					log_discovery(rq.msg_id, rq.src_node, rq.dest_node, rq.from_node);
					queue_result(make_res(ACT_BCAST, rq.msg_id, rq.src_node, rq.dest_node,
						0, 0, 0));
				end
			end
			KIND_REP: begin
				// Weighted average of the carried metric and the measured link strength.
				mag = rq.link_rssi[7] ? 32'd256 - {24'd0, rq.link_rssi} : {24'd0, rq.link_rssi};
				avg = ({16'd0, rq.reply_metric} * {24'd0, rq.reply_hops} + mag)
					/ ({24'd0, rq.reply_hops} + 32'd1);
				if (avg < {16'd0, rt_metric}) begin
					rt_target = rq.dest_node;
					rt_hops = rq.reply_hops;
					rt_next = rq.from_node;
					rt_age = route_life;
					rt_valid = 1;
					rt_metric = avg[15:0];
					changed = 1;
					if (rq.src_node != my_addr) begin
						for (int i = 0; i < DEPTH; i++) begin
							if (tbl_valid[i] && tbl_id[i] == rq.msg_id
									&& tbl_src[i] == rq.src_node) begin
								queue_result(make_res(ACT_REPLY, rq.msg_id, rq.src_node,
									rq.dest_node, tbl_snd[i], sat_inc(rq.reply_hops),
									avg[15:0]));
								tbl_valid[i] = 0;
							end
						end
					end
					for (int i = 0; i < DEPTH; i++)
						if (tbl_valid[i] && tbl_id[i] == rq.msg_id && tbl_src[i] == rq.src_node
								&& tbl_dest[i] == rq.dest_node)
							tbl_valid[i] = 0;
				end
			end
			default: begin
				// Age tick: an age of zero means the item never expires.
				if (rt_valid && rt_age > 0) begin
					rt_age = rt_age - 1;
					if (rt_age == 0) begin
						rt_valid = 0;
						rt_next = NO_NEXT;
						rt_hops = nr_hops;
						rt_metric = nr_rssi;
						changed = 1;
					end
				end
				for (int i = 0; i < DEPTH; i++) begin
					if (tbl_valid[i] && tbl_age[i] > 0) begin
						tbl_age[i] = tbl_age[i] - 1;
						if (tbl_age[i] == 0)
							tbl_valid[i] = 0;
					end
				end
			end
		endcase
		if (step_results.size() == 0)
			queue_result(make_res(ACT_NONE, 0, 0, 0, 0, 0, 0));
		foreach (step_results[k]) begin
			r = step_results[k];
			r.route_changed = changed;
			r.last = (k == step_results.size() - 1);
			expected_results.push_back(r);
		end
	endfunction

	// Result side: random ready with occasional long stalls, plus a forced hold-off.
	always @(negedge clk) begin
		if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			out_ch.ready <= 0;
		end else if (no_idle) begin
			out_ch.ready <= 1;
		end else if (stall_left > 0) begin
			stall_left <= stall_left - 1;
			out_ch.ready <= 0;
		end else begin
			if ($urandom_range(0, 149) == 0)
				stall_left <= $urandom_range(15, 60);
			out_ch.ready <= ($urandom_range(0, 99) < 70);
		end
	end

	// Checks each accepted result against the oldest expectation.
	always @(posedge clk) begin
		res_t want, got;
		if (arst_n && out_ch.valid && out_ch.ready) begin
			got = out_ch.data;
			results_seen++;
			if (got.action == ACT_REPLY)
				forwards_seen++;
			if (expected_results.size() == 0) begin
				errors++;
				$display("%t unexpected result: actual %p", $realtime, got);
			end else begin
				want = expected_results.pop_front();
				if (got !== want) begin
					errors++;
					$display("%t result mismatch: expected %p actual %p", $realtime, want, got);
				end
			end
		end
	end

	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (no_idle || r < 45)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// Offers one request, waits for the handshake, then idles for a random gap.
	task automatic send_request(req_t rq);
		int gap;
		@(negedge clk);
		in_ch.data = rq;
		in_ch.valid = 1;
		do @(posedge clk); while (!in_ch.ready);
		predict_results(rq);
		requests_sent++;
		gap = gap_len();
		if (gap > 0) begin
			@(negedge clk);
			in_ch.valid = 0;
			repeat (gap - 1) @(negedge clk);
		end
	endtask

	task automatic send_event(logic [1:0] kind, logic [7:0] id, logic [7:0] src,
			logic [7:0] dest, logic [7:0] from, logic [7:0] hops = 0,
			logic [15:0] met = 0, logic [7:0] rssi = 0);
		req_t rq;
		rq.kind = kind;
		rq.msg_id = id;
		rq.src_node = src;
		rq.dest_node = dest;
		rq.from_node = from;
		rq.reply_hops = hops;
		rq.reply_metric = met;
		rq.link_rssi = rssi;
		send_request(rq);
	endtask

	// Lowers valid and waits until every expected result has arrived.
	task automatic drain();
		@(negedge clk);
		in_ch.valid = 0;
		wait (expected_results.size() == 0);
		repeat (8) @(posedge clk);
	endtask

	// Register write followed by a read-back; called only while the engine is idle.
	task automatic write_reg(logic [2:0] idx, logic [31:0] value);
		logic [31:0] want;
		case (idx)
			REG_ADDR: begin my_addr = value[7:0]; want = {24'd0, value[7:0]}; end
			REG_RLIFE: begin route_life = value[15:0]; want = {16'd0, value[15:0]}; end
			REG_DLIFE: begin disc_life = value[15:0]; want = {16'd0, value[15:0]}; end
			REG_NRSSI: begin nr_rssi = value[15:0]; want = {16'd0, value[15:0]}; end
			default: begin nr_hops = value[7:0]; want = {24'd0, value[7:0]}; end
		endcase
		@(negedge clk);
		psel = 1;
		penable = 0;
		pwrite = 1;
		paddr = {idx, 2'b00};
		pwdata = value;
		@(negedge clk);
		penable = 1;
		@(negedge clk);
		penable = 0;
		pwrite = 0;
		@(negedge clk);
		penable = 1;
		@(posedge clk);
		if (prdata !== want) begin
			errors++;
			$display("%t register %0d read-back: expected %h actual %h", $realtime, idx,
				want, prdata);
		end
		@(negedge clk);
		psel = 0;
		penable = 0;
	endtask

	task automatic configure(logic [7:0] addr, logic [15:0] rlife, logic [15:0] dlife,
			logic [15:0] rssi, logic [7:0] hops);
		drain();
		write_reg(REG_ADDR, addr);
		write_reg(REG_RLIFE, rlife);
		write_reg(REG_DLIFE, dlife);
		write_reg(REG_NRSSI, rssi);
		write_reg(REG_NHOPS, hops);
	endtask

	// Own discoveries, replies to self, duplicates and a table that overflows.
	task automatic test_discovery_table();
		send_event(KIND_DISC, 8'd5, 8'd0, 8'd9, 8'd0);
		send_event(KIND_REQ, 8'd6, 8'd3, my_addr, 8'd4);
		send_event(KIND_REQ, 8'd5, my_addr, 8'd9, 8'd7);
		for (int i = 0; i < 8; i++)
			send_event(KIND_DISC, 8'd20 + i[7:0], 8'd0, 8'd30, 8'd0);
		// Discovery lifetime is ten ticks, so this empties the table.
		repeat (10) send_event(KIND_TICK, 8'd0, 8'd0, 8'd0, 8'd0);
	endtask

	// Logged requests, a reply that fans out, one that does not improve the route,
	// a request answered from the route, and a reply back to this node.
	task automatic test_reply_forwarding();
		send_event(KIND_REQ, 8'd7, 8'd3, 8'd9, 8'd4);
		send_event(KIND_REQ, 8'd7, 8'd3, 8'd10, 8'd5);
		send_event(KIND_REQ, 8'd7, 8'd3, 8'd11, 8'd6);
		send_event(KIND_REP, 8'd7, 8'd3, 8'd9, 8'd12, 8'd2, 16'd100, -8'sd50);
		send_event(KIND_REP, 8'd7, 8'd3, 8'd9, 8'd13, 8'd255, 16'hFFFF, -8'sd128);
		send_event(KIND_REQ, 8'd9, 8'd8, 8'd14, 8'd15);
		send_event(KIND_DISC, 8'd40, 8'd0, 8'd41, 8'd0);
		send_event(KIND_REP, 8'd40, my_addr, 8'd41, 8'd16, 8'd0, 16'd0, 8'sd0);
	endtask

	// Ticks under a short route lifetime, a reply with a hop count of 255, and a request answered from the route.
	task automatic test_route_aging();
		configure(8'd0, 16'd2, 16'd3, 16'hFFFF, 8'hFF);
		repeat (3) send_event(KIND_TICK, 8'd0, 8'd0, 8'd0, 8'd0);
		send_event(KIND_REP, 8'd1, 8'd2, 8'd3, 8'd4, 8'd255, 16'd1000, 8'sd127);
		send_event(KIND_REQ, 8'd1, 8'd9, 8'd3, 8'd8);
		repeat (2) send_event(KIND_TICK, 8'd0, 8'd0, 8'd0, 8'd0);
	endtask

	// Lifetimes of zero: a table entry that never expires, seen as a duplicate after the ticks.
	task automatic test_zero_lifetime();
		configure(8'd255, 16'd0, 16'd0, 16'd0, 8'd0);
		send_event(KIND_DISC, 8'd2, 8'd0, 8'd254, 8'd0);
		repeat (3) send_event(KIND_TICK, 8'd0, 8'd0, 8'd0, 8'd0);
		send_event(KIND_REQ, 8'd2, 8'd255, 8'd254, 8'd1);
	endtask

	function automatic logic [7:0] pick_node(logic [7:0] own);
		int r;
		r = $urandom_range(0, 9);
		if (r < 2) return own;
		if (r < 8) return $urandom_range(2, 5);
		return $urandom_range(0, 255);
	endfunction

	// Random traffic: a small pool of ids and nodes makes duplicates, matches and
	// forwards frequent, with occasional fully random packets as noise.
	task automatic random_traffic(int count);
		req_t rq;
		int r;
		for (int n = 0; n < count; n++) begin
			r = $urandom_range(0, 99);
			rq.kind = (r < 20) ? KIND_DISC : (r < 55) ? KIND_REQ : (r < 80) ? KIND_REP :
				KIND_TICK;
			rq.msg_id = ($urandom_range(0, 9) < 8) ? $urandom_range(0, 3) :
				$urandom_range(0, 255);
			rq.src_node = pick_node(my_addr);
			rq.dest_node = pick_node(my_addr);
			rq.from_node = $urandom_range(0, 255);
			rq.reply_hops = ($urandom_range(0, 9) < 7) ? $urandom_range(0, 6) :
				$urandom_range(0, 255);
			rq.reply_metric = ($urandom_range(0, 9) < 5) ? $urandom_range(0, 300) :
				$urandom_range(0, 65535);
			rq.link_rssi = $urandom_range(0, 255);
			send_request(rq);
		end
	endtask

	task automatic test_random_settings();
		configure(8'd3, 16'd6, 16'd8, 16'hFFFF, 8'hFF);
		random_traffic(20);
		configure(8'd0, 16'd1, 16'd1, 16'd40000, 8'd0);
		random_traffic(15);
		configure(8'd255, 16'hFFFF, 16'hFFFF, 16'hFFFF, 8'd200);
		random_traffic(15);
		configure($urandom_range(0, 255), $urandom_range(2, 12), $urandom_range(2, 12),
			$urandom_range(1000, 65535), $urandom_range(0, 255));
		random_traffic(20);
		// A stretch with no idling on either side.
		no_idle = 1;
		random_traffic(10);
		no_idle = 0;
	endtask

	// The result side holds off long enough for the engine to stall its input while
	// requests keep coming; then the sender waits for a full drain.
	task automatic test_backpressure();
		configure(8'd1, 16'd20, 16'd20, 16'hFFFF, 8'hFF);
		hold_left = 300;
		no_idle = 1;
		random_traffic(15);
		no_idle = 0;
		drain();
		random_traffic(15);
	endtask

	initial begin
		arst_n = 0;
		in_ch.valid = 0;
		in_ch.data = '0;
		out_ch.ready = 0;
		psel = 0;
		penable = 0;
		pwrite = 0;
		paddr = '0;
		pwdata = '0;
		my_addr = 8'd1;
		route_life = 16'd60;
		disc_life = 16'd10;
		nr_rssi = 16'hFFFF;
		nr_hops = 8'hFF;
		rt_valid = 0;
		rt_next = NO_NEXT;
		rt_hops = 8'hFF;
		rt_metric = 16'hFFFF;
		rt_age = 0;
		rt_target = 0;
		for (int i = 0; i < DEPTH; i++) begin
			tbl_valid[i] = 0;
			tbl_id[i] = 0;
			tbl_src[i] = 0;
			tbl_dest[i] = 0;
			tbl_snd[i] = 0;
			tbl_age[i] = 0;
		end
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1;

		test_discovery_table();
		test_reply_forwarding();
		test_route_aging();
		test_zero_lifetime();
		test_random_settings();
		test_backpressure();

		drain();
		repeat (40) @(posedge clk);
		$display("Sent %0d requests over eight register settings and checked %0d results",
			requests_sent, results_seen);
		$display("(%0d unicast replies), including a long result-side hold-off.",
			forwards_seen);
		if (errors == 0 && expected_results.size() == 0) begin
			$display("PASS route_discovery_table_engine");
		end else begin
			$display("FAIL route_discovery_table_engine");
		end
		$finish;
	end
endmodule
